// ----- sv/ckd_pkg.sv -----
`default_nettype none
package ckd_pkg;
  localparam int VALUE_BITS_DEF = 8;
  localparam int MAX_SEQ_DEF = 1024;
  localparam int LIMIT_W = 9;
  localparam int RUNS_W = 11;
  localparam int TOTAL_W = 20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd1;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic begin_item;
    logic adm_wr;
    logic shr_hist;
    logic shr_wr;
    logic finish;
    logic win;
  } ckd_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic full;
    logic shrink_needed;
  } ckd_sts_t;
endpackage
`default_nettype wire

// ----- sv/ckd_ram.sv -----
`default_nettype none
module ckd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/ckd_datapath.sv -----
`default_nettype none
module ckd_datapath import ckd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_SEQ = MAX_SEQ_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ckd_cmd_t           cmd,
  output ckd_sts_t                sts,
  input  wire logic [7:0]         sample_value,
  input  wire logic               start_sequence,
  input  wire logic [LIMIT_W-1:0] distinct_limit,
  output logic [RUNS_W-1:0]       runs,
  output logic [TOTAL_W-1:0]      total,
  output logic                    drop
);
  localparam int VC = 1 << VALUE_BITS;
  localparam int AW = $clog2(MAX_SEQ);
  localparam int PW = $clog2(MAX_SEQ + 1);
  localparam int FW = PW;
  localparam int DW = VALUE_BITS + 1;
  localparam logic [PW-1:0] MAXP = PW'(MAX_SEQ);

  logic [VALUE_BITS-1:0] value, clr_idx, old_val;
  logic [PW-1:0] position, left_w, left_n;
  logic [DW-1:0] dist_w, dist_n;
  logic [TOTAL_W-1:0] total_count;
  logic [FW-1:0] frd_w, frd_n;
  logic [7:0] hrd;
  logic [VALUE_BITS-1:0] fadr;
  logic [FW-1:0] fwd, fcur;
  logic fwe_w, fwe_n, hwe;
  logic [DW-1:0] dist_cur;
  logic [PW-1:0] left_cur;
  logic [LIMIT_W-1:0] lim_cur;
  logic [PW:0] span_w, span_n;

  assign dist_cur = cmd.win ? dist_n : dist_w;
  assign left_cur = cmd.win ? left_n : left_w;
  assign lim_cur = cmd.win ? ((distinct_limit == '0) ? '0 : distinct_limit - 1'b1)
                           : distinct_limit;
  assign fcur = cmd.win ? frd_n : frd_w;

  // table addresses: clear sweep, admit value or departing history value
  always_comb begin
    fadr = value;
    if (cmd.clr_step) fadr = clr_idx;
    else if (cmd.shr_hist) fadr = hrd[VALUE_BITS-1:0];
    else if (cmd.shr_wr) fadr = old_val;
    fwd = '0;
    if (cmd.adm_wr) fwd = fcur + 1'b1;
    else if (cmd.shr_wr) fwd = (fcur != '0) ? fcur - 1'b1 : fcur;
    fwe_w = cmd.clr_step || ((cmd.adm_wr || (cmd.shr_wr && fcur != '0)) && !cmd.win);
    fwe_n = cmd.clr_step || ((cmd.adm_wr || (cmd.shr_wr && fcur != '0)) && cmd.win);
    hwe = cmd.begin_item && !sts.full;
  end

  ckd_ram #(.WIDTH(FW), .DEPTH(VC)) u_fw (.clk, .we(fwe_w), .waddr(fadr), .wdata(fwd),
    .raddr(fadr), .rdata(frd_w));
  ckd_ram #(.WIDTH(FW), .DEPTH(VC)) u_fn (.clk, .we(fwe_n), .waddr(fadr), .wdata(fwd),
    .raddr(fadr), .rdata(frd_n));
  // a new sequence starts at entry zero
  ckd_ram #(.WIDTH(8), .DEPTH(MAX_SEQ)) u_hist (.clk, .we(hwe),
    .waddr(cmd.clr_start ? '0 : position[AW-1:0]),
    .wdata(sample_value), .raddr(left_cur[AW-1:0]), .rdata(hrd));

  assign sts.clr_done = (clr_idx == VALUE_BITS'(VC - 1));
  assign sts.full = (position >= MAXP) && !start_sequence;
  assign sts.shrink_needed = (32'(dist_cur) > 32'(lim_cur)) &&
                             (left_cur <= position) && (left_cur < MAXP);
  assign span_w = {1'b0, position} + 1'b1 - {1'b0, left_w};
  assign span_n = {1'b0, position} + 1'b1 - {1'b0, left_n};

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
    if (cmd.begin_item) begin
      value <= sample_value[VALUE_BITS-1:0];
      drop <= sts.full;
    end
    if (rst || cmd.clr_start) begin
      position <= '0; left_w <= '0; left_n <= '0;
      dist_w <= '0; dist_n <= '0; total_count <= '0;
    end else begin
      if (cmd.shr_hist) old_val <= hrd[VALUE_BITS-1:0];
      if (cmd.adm_wr && fcur == '0) begin
        if (cmd.win) dist_n <= dist_n + 1'b1;
        else dist_w <= dist_w + 1'b1;
      end
      if (cmd.shr_wr) begin
        if (fcur == FW'(1) && dist_cur != '0) begin
          if (cmd.win) dist_n <= dist_n - 1'b1;
          else dist_w <= dist_w - 1'b1;
        end
        if (cmd.win) left_n <= left_n + 1'b1;
        else left_w <= left_w + 1'b1;
      end
      if (cmd.finish && !drop) begin
        runs <= (span_w > span_n) ? RUNS_W'(span_w - span_n) : '0;
        if ({1'b0, total_count} + (TOTAL_W+1)'((span_w > span_n) ? span_w - span_n : '0)
            > (TOTAL_W+1)'({TOTAL_W{1'b1}}))
          total_count <= '1;
        else
          total_count <= total_count + TOTAL_W'((span_w > span_n) ? span_w - span_n : '0);
        position <= position + 1'b1;
      end else if (cmd.finish) begin
        runs <= '0;
      end
    end
  end
  assign total = total_count;
endmodule
`default_nettype wire

// ----- sv/ckd_ctrl.sv -----
`default_nettype none
module ckd_ctrl import ckd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     in_start,
  output logic          out_load,
  input  wire logic     out_free,
  input  wire ckd_sts_t sts,
  output ckd_cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_RCLR, S_IDLE, S_CLR, S_ADM_RD, S_ADM_WR, S_CHK, S_SHR_RD, S_SHR_H, S_SHR_WR,
    S_DONE
  } state_t;
  state_t state;
  logic win;

  assign in_stall = (state != S_IDLE) || !out_free;

  always_comb begin
    cmd = '0;
    cmd.win = win;
    cmd.begin_item = (state == S_IDLE) && in_valid && !in_stall;
    cmd.clr_start = cmd.begin_item && in_start;
    cmd.clr_step = (state == S_CLR) || (state == S_RCLR);
    cmd.adm_wr = (state == S_ADM_WR);
    cmd.shr_hist = (state == S_SHR_H);
    cmd.shr_wr = (state == S_SHR_WR);
    cmd.finish = (state == S_DONE);
  end
  assign out_load = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR; win <= 1'b0;
    end else begin
      unique case (state)
        S_RCLR: if (sts.clr_done) state <= S_IDLE;
        S_IDLE: if (cmd.begin_item) begin
          win <= 1'b0;
          if (in_start) state <= S_CLR;
          else if (sts.full) state <= S_DONE;
          else state <= S_ADM_RD;
        end
        S_CLR: if (sts.clr_done) state <= S_ADM_RD;
        S_ADM_RD: state <= S_ADM_WR;
        S_ADM_WR: state <= S_CHK;
        S_CHK: begin
          if (sts.shrink_needed) state <= S_SHR_RD;
          else if (!win) begin win <= 1'b1; state <= S_ADM_RD; end
          else state <= S_DONE;
        end
        S_SHR_RD: state <= S_SHR_H;
        S_SHR_H: state <= S_SHR_WR;
        S_SHR_WR: state <= S_CHK;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/count_windows_exactly_k_distinct_unit.sv -----
// Exactly-k-distinct run counter.
// Input channel: sample_value, start_sequence with valid/stall; one beat per element.
// Output channel: runs_ending_here, running_total, dropped with valid/stall.
// Config channel: cfg_valid/cfg_ready writes distinct_limit (reset 1); write only
// when idle.
// Each element is admitted to each window (read, write, check); every element that
// leaves a window adds a read, a history read and a write before the check again,
// as the frequency tables are walked through a single port. Then the element is
// finished and the output register is loaded. A dropped element skips admission
// and goes straight to the finish step. A start_sequence beat first sweeps both
// tables over all 2^VALUE_BITS entries. After reset the same sweep runs while
// input is stalled. The result sits in an output register; the next element is
// taken only once that register holds no beat the receiver still has to take, so
// one element is in flight at a time and a stalled receiver holds the block.
`default_nettype none
module count_windows_exactly_k_distinct_unit import ckd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_SEQ = MAX_SEQ_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         sample_value,
  input  wire logic               start_sequence,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [RUNS_W-1:0]       runs_ending_here,
  output logic [TOTAL_W-1:0]      running_total,
  output logic                    dropped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);
  ckd_cmd_t cmd;
  ckd_sts_t sts;
  logic out_load, out_free;
  logic [LIMIT_W-1:0] distinct_limit;
  logic [RUNS_W-1:0] runs;
  logic [TOTAL_W-1:0] total;
  logic drop;
  logic load_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) distinct_limit <= LIMIT_RESET;
    else if (cfg_valid) distinct_limit <= cfg_data;
  end

  ckd_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .in_start(start_sequence),
    .out_load, .out_free, .sts, .cmd);
  ckd_datapath #(.VALUE_BITS(VALUE_BITS), .MAX_SEQ(MAX_SEQ)) u_dp (.clk, .rst, .cmd,
    .sts, .sample_value, .start_sequence, .distinct_limit, .runs, .total, .drop);

  // hold input while a result is on its way into the output register or a stalled beat waits in it
  assign out_free = !load_q && (!out_valid || !out_stall);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; load_q <= 1'b0;
    end else begin
      load_q <= out_load;
      if (load_q) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (load_q) begin
      runs_ending_here <= runs;
      running_total <= total;
      dropped <= drop;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(runs_ending_here) &&
      $stable(running_total) && $stable(dropped));
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_q |-> !out_valid);
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> runs_ending_here == '0);
endmodule
`default_nettype wire
